// ----- hw/rtl/vn_pkg.sv -----
// Package: shared types and constants for the vector normalize unit.
package vn_pkg;

	localparam int CompW  = 16;
	localparam int SumW   = 32;
	localparam int RootW  = 16;
	localparam int QuotW  = 15;
	localparam int RemW   = 17;
	localparam int Lanes  = 3;
	localparam int DivSteps = QuotW;

	// Payload handed along the square root cells
	typedef struct packed {
		logic [SumW-1:0]              rem;
		logic [RootW-1:0]             root;
		logic [Lanes-1:0][CompW-1:0]  mag_c;
		logic [Lanes-1:0]             neg;
	} sqrt_t;

	// Payload handed along the divider cells
	typedef struct packed {
		logic [RootW-1:0]             mag;
		logic [Lanes-1:0][RemW-1:0]   rem;
		logic [Lanes-1:0][QuotW-1:0]  quot;
		logic [Lanes-1:0]             neg;
	} div_t;

endpackage

// ----- hw/rtl/vn_sqrt_cell.sv -----
// One root bit of the integer square root, registered.
module vn_sqrt_cell #(
	parameter int BitPos = 0
) (
	input  logic          clk,
	input  logic          en,
	input  vn_pkg::sqrt_t d,
	output vn_pkg::sqrt_t q
);
	import vn_pkg::*;

	logic [SumW:0] trial;
	logic [SumW:0] rem_w;
	sqrt_t         nxt;

	// trial = root * 2^(p+1) + 4^p, compare against remainder
	always_comb begin
		trial = (SumW+1)'({{(SumW+1-RootW){1'b0}}, d.root} << (BitPos + 1))
			+ ((SumW+1)'(1) << (2 * BitPos));
		rem_w = {1'b0, d.rem};
		nxt = d;
		if (rem_w >= trial) begin
			nxt.rem  = SumW'(rem_w - trial);
			nxt.root = d.root | (RootW'(1) << BitPos);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- hw/rtl/vn_div_cell.sv -----
// One quotient bit for all three lanes of the divide, registered.
module vn_div_cell #(
	parameter bit Shift = 1'b1
) (
	input  logic         clk,
	input  logic         en,
	input  vn_pkg::div_t d,
	output vn_pkg::div_t q
);
	import vn_pkg::*;

	logic [RemW-1:0] part;
	logic [RemW-1:0] dvs;
	div_t            nxt;

	// restoring step per lane
	always_comb begin
		nxt  = d;
		dvs  = {1'b0, d.mag};
		part = '0;
		for (int i = 0; i < Lanes; i++) begin
			part = Shift ? {d.rem[i][RemW-2:0], 1'b0} : d.rem[i];
			if (part >= dvs) begin
				nxt.rem[i]  = part - dvs;
				nxt.quot[i] = {d.quot[i][QuotW-2:0], 1'b1};
			end else begin
				nxt.rem[i]  = part;
				nxt.quot[i] = {d.quot[i][QuotW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

// ----- hw/rtl/vector3_normalize_unit.sv -----
// Top level: 3-vector magnitude and Q1.14 unit vector, fully pipelined.
//
//  channel | valid     | stall      | payload
//  in      | in_valid  | in_stall   | comp_x, comp_y, comp_z
//  out     | out_valid | out_stall  | unit_x/y/z, magnitude, zero_length
//
// One request per cycle while the output is not stalled; one squaring stage, 16 square
// root cells (one root bit each) and 15 divider cells (one quotient bit each).
// arst_n clears the stage valid bits only; payload registers are not reset.
// Each stage moves when it is empty or the one after it moves, so bubbles
// close up and a stalled output holds only the stages queued behind it.
module vector3_normalize_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] comp_x,
	input  logic [15:0] comp_y,
	input  logic [15:0] comp_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] unit_x,
	output logic [15:0] unit_y,
	output logic [15:0] unit_z,
	output logic [15:0] magnitude,
	output logic        zero_length
);
	import vn_pkg::*;

	localparam int SqrtN   = RootW;
	localparam int Stages  = 1 + SqrtN + DivSteps;

	logic [Stages-1:0] v_q;
	logic [Stages-1:0] en;

	logic [Lanes-1:0][CompW-1:0] abs_in;
	logic [Lanes-1:0]            neg_in;
	logic [Lanes-1:0][SumW-1:0]  sq_s1;
	logic [Lanes-1:0][CompW-1:0] abs_s1;
	logic [Lanes-1:0]            neg_s1;

	sqrt_t sq_chain [SqrtN+1];
	div_t  dv_chain [DivSteps+1];

	// stage enables, ripple back from the output
	always_comb begin
		en[Stages-1] = !v_q[Stages-1] || !out_stall;
		for (int i = Stages - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign in_stall = !en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = Stages - 1; i > 0; i--) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
		end
	end

	// absolute values and signs
	always_comb begin
		abs_in[0] = comp_x[15] ? CompW'(-comp_x) : comp_x;
		abs_in[1] = comp_y[15] ? CompW'(-comp_y) : comp_y;
		abs_in[2] = comp_z[15] ? CompW'(-comp_z) : comp_z;
		neg_in    = {comp_z[15], comp_y[15], comp_x[15]};
	end

	// squaring stage
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < Lanes; i++) begin
				sq_s1[i] <= SumW'(abs_in[i]) * SumW'(abs_in[i]);
			end
			abs_s1 <= abs_in;
			neg_s1 <= neg_in;
		end
	end

	// sum of squares seeds the root chain
	always_comb begin
		sq_chain[0].rem   = sq_s1[0] + sq_s1[1] + sq_s1[2];
		sq_chain[0].root  = '0;
		sq_chain[0].mag_c = abs_s1;
		sq_chain[0].neg   = neg_s1;
	end

	for (genvar k = 0; k < SqrtN; k++) begin : g_sqrt
		vn_sqrt_cell #(
			.BitPos(SqrtN - 1 - k)
		) u_cell (
			.clk(clk),
			.en (en[1+k]),
			.d  (sq_chain[k]),
			.q  (sq_chain[k+1])
		);
	end

	// root feeds the divider chain
	always_comb begin
		dv_chain[0].mag = sq_chain[SqrtN].root;
		for (int i = 0; i < Lanes; i++) begin
			dv_chain[0].rem[i]  = RemW'(sq_chain[SqrtN].mag_c[i]);
			dv_chain[0].quot[i] = '0;
		end
		dv_chain[0].neg = sq_chain[SqrtN].neg;
	end

	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		vn_div_cell #(
			.Shift(k != 0)
		) u_cell (
			.clk(clk),
			.en (en[1+SqrtN+k]),
			.d  (dv_chain[k]),
			.q  (dv_chain[k+1])
		);
	end

	// result formatting, zero vector forces zeros
	logic [Lanes-1:0][15:0] unit_w;
	always_comb begin
		zero_length = (dv_chain[DivSteps].mag == '0);
		for (int i = 0; i < Lanes; i++) begin
			if (zero_length) begin
				unit_w[i] = '0;
			end else if (dv_chain[DivSteps].neg[i]) begin
				unit_w[i] = 16'(-{1'b0, dv_chain[DivSteps].quot[i]});
			end else begin
				unit_w[i] = {1'b0, dv_chain[DivSteps].quot[i]};
			end
		end
	end

	assign out_valid = v_q[Stages-1];
	assign unit_x    = unit_w[0];
	assign unit_y    = unit_w[1];
	assign unit_z    = unit_w[2];
	assign magnitude = dv_chain[DivSteps].mag;
endmodule

// ----- tb/tb.sv -----
// Testbench for vector3_normalize_unit: predicted magnitude and unit vector checks.
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [15:0] ux;
		logic [15:0] uy;
		logic [15:0] uz;
		logic [15:0] mag;
		logic        zl;
	} norm_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] comp_x;
	logic [15:0] comp_y;
	logic [15:0] comp_z;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] unit_x;
	logic [15:0] unit_y;
	logic [15:0] unit_z;
	logic [15:0] magnitude;
	logic        zero_length;

	norm_t norm_q[$];
	int    errors;
	int    send_idle_pct;
	int    recv_stall_pct;

	vector3_normalize_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.magnitude(magnitude), .zero_length(zero_length)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// floor square root, one result bit per step
	function automatic logic [15:0] floor_root(logic [31:0] n);
		logic [31:0] root;
		logic [31:0] rem;
		logic [31:0] bitv;
		root = 0;
		rem = n;
		bitv = 32'h4000_0000;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root[15:0];
	endfunction

	function automatic logic [15:0] scaled_quot(logic signed [15:0] c, logic [15:0] m);
		logic [31:0] a;
		logic [31:0] q;
		a = c < 0 ? 32'(-32'(c)) : 32'(c);
		q = (a << 14) / m;
		return c < 0 ? 16'(-q) : q[15:0];
	endfunction

	function automatic norm_t normalize(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		norm_t r;
		logic [31:0] sum;
		logic [15:0] m;
		sum = 32'(x * x) + 32'(y * y) + 32'(z * z);
		m = floor_root(sum);
		if (m == 0) begin
			r = '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
		end else begin
			r = '{scaled_quot(x, m), scaled_quot(y, m), scaled_quot(z, m), m, 1'b0};
		end
		return r;
	endfunction

	// send one request, with random idle cycles first; valid stays up until
	// the next idle cycle or drain so back-to-back requests see no gap
	task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		comp_x <= x;
		comp_y <= y;
		comp_z <= z;
		norm_q.push_back(normalize(x, y, z));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// receiver stall and result check
	always @(posedge clk) begin
		norm_t got;
		norm_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{unit_x, unit_y, unit_z, magnitude, zero_length};
				if (norm_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = norm_q.pop_front();
					if (got.ux !== want.ux)
						$display("%0t: unit_x exp %h got %h", $time, want.ux, got.ux);
					if (got.uy !== want.uy)
						$display("%0t: unit_y exp %h got %h", $time, want.uy, got.uy);
					if (got.uz !== want.uz)
						$display("%0t: unit_z exp %h got %h", $time, want.uz, got.uz);
					if (got.mag !== want.mag)
						$display("%0t: magnitude exp %h got %h", $time, want.mag, got.mag);
					if (got.zl !== want.zl)
						$display("%0t: zero_length exp %b got %b", $time, want.zl, got.zl);
					if (got !== want) errors++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// drop valid and wait for every outstanding result
	task automatic drain;
		in_valid <= 1'b0;
		while (norm_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed;
		logic [15:0] ext[6];
		ext = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001};
		send_vector(0, 0, 0);
		send_vector(16'h8000, 16'h8000, 16'h8000);
		send_vector(16'h7FFF, 16'h7FFF, 16'h7FFF);
		for (int i = 0; i < 6; i++) begin
			send_vector(ext[i], 0, 0);
			send_vector(0, ext[i], 0);
			send_vector(0, 0, ext[i]);
		end
		send_vector(3, 4, 0);
		send_vector(16'hFFFD, 0, 16'hFFFC);
		drain();
	endtask

	// a quarter small, a quarter mid-range and half full-range components so that every bit toggles
	task automatic test_random(int n);
		logic [15:0] v[3];
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(3))
					0: v[k] = $urandom_range(16) - 8;
					1: v[k] = $urandom_range(2000) - 1000;
					default: v[k] = $urandom;
				endcase
			end
			send_vector(v[0], v[1], v[2]);
		end
	endtask

	task automatic test_idle_phases;
		send_idle_pct = 0;  recv_stall_pct = 0;  test_random(160);
		send_idle_pct = 47; recv_stall_pct = 0;  test_random(160);
		drain();
		send_idle_pct = 0;  recv_stall_pct = 47; test_random(160);
		send_idle_pct = 13; recv_stall_pct = 13; test_random(150);
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		comp_x = 0;
		comp_y = 0;
		comp_z = 0;
		out_stall = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_idle_phases();
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && norm_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
